// File: src/tcc_pkg.sv
package tcc_pkg;

    // Operation codes carried on the func field
    typedef enum logic [1:0] {
        FN_WRITE = 2'd0,
        FN_MOVE  = 2'd1,
        FN_CLEAR = 2'd2,
        FN_READ  = 2'd3
    } func_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_PUTCH,
        S_NEWLINE,
        S_SCROLL,
        S_FILL,
        S_MODCOL,
        S_MODROW,
        S_READ,
        S_DONE
    } state_t;

    // Configuration register indexes
    localparam logic [0:0] CFG_COLUMNS = 1'b0;
    localparam logic [0:0] CFG_ROWS    = 1'b1;

    // Character codes
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;

    // Reset values
    localparam logic [7:0] ATTR_RESET = 8'd7;
    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [5:0] ROWS_RESET = 6'd25;

    // Field widths
    localparam int TGT_W     = 8;   // target column / row width
    localparam int REM_W     = 9;   // remainder unit width
    localparam int DIV_CNT_W = 3;   // one step per target bit
    localparam int CELL_W    = 16;

endpackage

// File: src/text_console_cursor_scroll.sv
// Text console engine: a grid of character/attribute cells with a cursor and a
// current attribute, driven by one command beat per operation and answering
// with one result beat. A carriage return goes straight to S_DONE, a plain
// character is written in S_PUTCH, a wrapping character goes on through
// S_NEWLINE, and a newline from the last row goes on to S_SCROLL. For a move
// or a read, column and row are reduced by one shared bit-serial remainder
// unit, one bit per cycle, in S_MODCOL and S_MODROW. Clear and scroll pass over
// the grid through the single write port of the cell memory, one cell a cycle.
// The cell memory has no reset and no clearing pass; cells read before a clear
// has written them return undefined data. Configuration must be written only
// while the block is idle; the block itself does not enforce this. A result
// waiting on the output does not block the next command beat.
module text_console_cursor_scroll
    import tcc_pkg::*;
#(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] func,
    input  logic [7:0] char_code,
    input  logic [7:0] target_column,
    input  logic [7:0] target_row,
    input  logic [7:0] clear_attr,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] cursor_col,
    output logic [4:0] cursor_line,
    output logic [7:0] cell_char,
    output logic [7:0] cell_attr
);

    localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
    localparam int XW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int YW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNW = $clog2(MAX_COLUMNS + 1);
    localparam int RNW = $clog2(MAX_ROWS + 1);
    localparam int PW  = CNW + RNW;
    localparam int NW  = $clog2(CELL_COUNT + 1);
    localparam int AW  = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int OXW = (XW > 7) ? XW : 7;
    localparam int OYW = (YW > 5) ? YW : 5;

    // Control and configuration state
    state_t               state_reg, state_next;
    logic [7:0]           cols_reg;
    logic [5:0]           rows_reg;
    logic [XW-1:0]        cursor_x_reg, cursor_x_next;
    logic [YW-1:0]        cursor_y_reg, cursor_y_next;
    logic [7:0]           attr_reg, attr_next;
    logic                 pend_reg, pend_next;
    logic                 out_valid_reg, out_valid_next;

    // Operation payload
    func_t                func_reg, func_next;
    logic [7:0]           ch_reg, ch_next;
    logic [TGT_W-1:0]     trow_reg, trow_next;
    logic [TGT_W-1:0]     dvd_reg, dvd_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [XW-1:0]        col_rem_reg, col_rem_next;
    logic [YW-1:0]        row_rem_reg, row_rem_next;
    logic [NW-1:0]        cnt_reg, cnt_next;
    logic [NW-1:0]        n_reg, n_next;
    logic [NW-1:0]        pend_dst_reg, pend_dst_next;
    logic                 pend_keep_reg, pend_keep_next;
    logic [6:0]           col_out_reg, col_out_next;
    logic [4:0]           line_out_reg, line_out_next;
    logic [7:0]           char_out_reg, char_out_next;
    logic [7:0]           attr_out_reg, attr_out_next;

    // Cell memory
    logic [CELL_W-1:0]    mem [CELL_COUNT];
    logic [CELL_W-1:0]    rd_data_reg;
    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [CELL_W-1:0]    mem_wdata;

    // Datapath signals
    logic [REM_W-1:0]     cols_wide, rows_wide;
    logic [CNW-1:0]       c;
    logic [RNW-1:0]       r;
    logic [RNW-1:0]       mul_a;
    logic [XW-1:0]        mul_col;
    logic [PW-1:0]        prod, prod_sum;
    logic [AW-1:0]        cell_addr;
    logic [NW-1:0]        base;
    logic [NW-1:0]        scroll_src;
    logic [REM_W-1:0]     div_dvs, div_sh, rem_step;
    logic                 div_ge;
    logic                 div_last;
    logic [CNW-1:0]       cx_inc;
    logic [RNW-1:0]       cy_inc;
    logic [RNW-1:0]       r_last;
    logic                 wrap_x, last_row;
    logic                 finish, out_free;
    logic [OXW-1:0]       cx_ext;
    logic [OYW-1:0]       cy_ext;

    // Size registers in use: zero reads as one, large values saturate
    always_comb
    begin
        if (cols_reg == 8'd0)
            cols_wide = REM_W'(1);
        else if (REM_W'(cols_reg) > REM_W'(MAX_COLUMNS))
            cols_wide = REM_W'(MAX_COLUMNS);
        else
            cols_wide = REM_W'(cols_reg);
        if (rows_reg == 6'd0)
            rows_wide = REM_W'(1);
        else if (REM_W'(rows_reg) > REM_W'(MAX_ROWS))
            rows_wide = REM_W'(MAX_ROWS);
        else
            rows_wide = REM_W'(rows_reg);
    end

    assign c = CNW'(cols_wide);
    assign r = RNW'(rows_wide);

    // Address multiplier: row * columns + column, or rows * columns when idle
    always_comb
    begin
        if (state_reg == S_IDLE)
            mul_a = r;
        else if (state_reg == S_READ)
            mul_a = RNW'(row_rem_reg);
        else
            mul_a = RNW'(cursor_y_reg);
        mul_col = (state_reg == S_READ) ? col_rem_reg : cursor_x_reg;
    end

    assign prod      = PW'(mul_a) * PW'(c);
    assign prod_sum  = prod + PW'(mul_col);
    assign cell_addr = prod_sum[AW-1:0];

    // Scroll source: rows shift up, bottom row reads itself
    assign base       = n_reg - NW'(c);
    assign scroll_src = (cnt_reg < base) ? (cnt_reg + NW'(c)) : cnt_reg;

    // Shared remainder unit, one dividend bit per cycle
    assign div_dvs  = (state_reg == S_MODCOL) ? REM_W'(c) : REM_W'(r);
    assign div_sh   = {rem_reg[REM_W-2:0], dvd_reg[TGT_W-1]};
    assign div_ge   = (div_sh >= div_dvs);
    assign rem_step = div_ge ? (div_sh - div_dvs) : div_sh;
    assign div_last = (bit_cnt_reg == DIV_CNT_W'(TGT_W - 1));

    // Cursor advance
    assign cx_inc   = CNW'(cursor_x_reg) + CNW'(1);
    assign cy_inc   = RNW'(cursor_y_reg) + RNW'(1);
    assign r_last   = r - RNW'(1);
    assign wrap_x   = (cx_inc >= c);
    assign last_row = (cy_inc >= r);

    assign out_free = !out_valid_reg || !out_stall;

    // End of the current operation
    always_comb
    begin
        case (state_reg)
            S_PUTCH:   finish = !wrap_x;
            S_NEWLINE: finish = !last_row;
            S_SCROLL:  finish = (cnt_reg == n_reg) && !pend_reg;
            S_FILL:    finish = (cnt_reg == n_reg);
            S_MODROW:  finish = div_last && (func_reg == FN_MOVE);
            S_DONE:    finish = 1'b1;
            default:   finish = 1'b0;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (func_t'(func))
                        FN_WRITE:
                        begin
                            if (char_code == CH_NEWLINE)
                                state_next = S_NEWLINE;
                            else if (char_code == CH_RETURN)
                                state_next = S_DONE;
                            else
                                state_next = S_PUTCH;
                        end
                        FN_MOVE:  state_next = S_MODCOL;
                        FN_CLEAR: state_next = S_FILL;
                        FN_READ:  state_next = S_MODCOL;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_PUTCH:
            begin
                if (wrap_x)
                    state_next = S_NEWLINE;
            end
            S_NEWLINE:
            begin
                if (last_row)
                    state_next = S_SCROLL;
            end
            S_MODCOL:
            begin
                if (div_last)
                    state_next = S_MODROW;
            end
            S_MODROW:
            begin
                if (div_last && (func_reg != FN_MOVE))
                    state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
        if (finish)
            state_next = out_free ? S_IDLE : S_DONE;
    end

    // Datapath and memory control
    always_comb
    begin
        cursor_x_next  = cursor_x_reg;
        cursor_y_next  = cursor_y_reg;
        attr_next      = attr_reg;
        func_next      = func_reg;
        ch_next        = ch_reg;
        trow_next      = trow_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        bit_cnt_next   = bit_cnt_reg;
        col_rem_next   = col_rem_reg;
        row_rem_next   = row_rem_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        pend_next      = pend_reg;
        pend_dst_next  = pend_dst_reg;
        pend_keep_next = pend_keep_reg;
        mem_we         = 1'b0;
        mem_waddr      = cell_addr;
        mem_wdata      = {attr_reg, ch_reg};
        mem_re         = 1'b0;
        mem_raddr      = cell_addr;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next    = func_t'(func);
                    ch_next      = char_code;
                    trow_next    = target_row;
                    dvd_next     = target_column;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    cnt_next     = '0;
                    n_next       = prod[NW-1:0];
                    if (func_t'(func) == FN_CLEAR)
                    begin
                        attr_next     = clear_attr;
                        cursor_x_next = '0;
                        cursor_y_next = '0;
                    end
                end
            end
            S_PUTCH:
            begin
                mem_we = 1'b1;
                if (!wrap_x)
                    cursor_x_next = cx_inc[XW-1:0];
            end
            S_NEWLINE:
            begin
                cursor_x_next = '0;
                cnt_next      = '0;
                pend_next     = 1'b0;
                if (last_row)
                    cursor_y_next = r_last[YW-1:0];
                else
                    cursor_y_next = cy_inc[YW-1:0];
            end
            S_SCROLL:
            begin
                // read one cell ahead, write the previous one
                if (cnt_reg < n_reg)
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = scroll_src[AW-1:0];
                    cnt_next       = cnt_reg + NW'(1);
                    pend_next      = 1'b1;
                    pend_dst_next  = cnt_reg;
                    pend_keep_next = (cnt_reg < base);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_dst_reg[AW-1:0];
                    mem_wdata = pend_keep_reg ? rd_data_reg
                                              : {rd_data_reg[15:8], CH_SPACE};
                end
            end
            S_FILL:
            begin
                if (cnt_reg < n_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt_reg[AW-1:0];
                    mem_wdata = {attr_reg, CH_SPACE};
                    cnt_next  = cnt_reg + NW'(1);
                end
            end
            S_MODCOL:
            begin
                rem_next     = rem_step;
                dvd_next     = {dvd_reg[TGT_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + DIV_CNT_W'(1);
                if (div_last)
                begin
                    col_rem_next = rem_step[XW-1:0];
                    dvd_next     = trow_reg;
                    rem_next     = '0;
                end
            end
            S_MODROW:
            begin
                rem_next     = rem_step;
                dvd_next     = {dvd_reg[TGT_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + DIV_CNT_W'(1);
                if (div_last)
                begin
                    row_rem_next = rem_step[YW-1:0];
                    if (func_reg == FN_MOVE)
                    begin
                        cursor_x_next = col_rem_reg;
                        cursor_y_next = rem_step[YW-1:0];
                    end
                end
            end
            S_READ:
            begin
                mem_re = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Result register
    assign cx_ext = OXW'(cursor_x_next);
    assign cy_ext = OYW'(cursor_y_next);

    always_comb
    begin
        col_out_next  = col_out_reg;
        line_out_next = line_out_reg;
        char_out_next = char_out_reg;
        attr_out_next = attr_out_reg;
        out_valid_next = out_stall ? out_valid_reg : 1'b0;
        if (finish && out_free)
        begin
            out_valid_next = 1'b1;
            col_out_next   = cx_ext[6:0];
            line_out_next  = cy_ext[4:0];
            if (func_reg == FN_READ)
            begin
                char_out_next = rd_data_reg[7:0];
                attr_out_next = rd_data_reg[15:8];
            end
            else
            begin
                char_out_next = 8'd0;
                attr_out_next = 8'd0;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cols_reg      <= COLS_RESET;
            rows_reg      <= ROWS_RESET;
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            attr_reg      <= ATTR_RESET;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            attr_reg      <= attr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_COLUMNS: cols_reg <= cfg_data;
                    CFG_ROWS:    rows_reg <= cfg_data[5:0];
                    default:     cols_reg <= cols_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        ch_reg        <= ch_next;
        trow_reg      <= trow_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        bit_cnt_reg   <= bit_cnt_next;
        col_rem_reg   <= col_rem_next;
        row_rem_reg   <= row_rem_next;
        cnt_reg       <= cnt_next;
        n_reg         <= n_next;
        pend_dst_reg  <= pend_dst_next;
        pend_keep_reg <= pend_keep_next;
        col_out_reg   <= col_out_next;
        line_out_reg  <= line_out_next;
        char_out_reg  <= char_out_next;
        attr_out_reg  <= attr_out_next;
    end

    // Cell memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign cursor_col  = col_out_reg;
    assign cursor_line = line_out_reg;
    assign cell_char   = char_out_reg;
    assign cell_attr   = attr_out_reg;

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
    import tcc_pkg::*;

    localparam int MAX_COLUMNS    = 128;
    localparam int MAX_ROWS       = 32;
    localparam int CELLS          = MAX_COLUMNS * MAX_ROWS;
    localparam int RANDOM_CMDS    = 1080;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TIMEOUT_CYCLES = 3_000_000;

    // one command beat as queued for the sender
    typedef struct {
        func_t      fn;
        logic [7:0] ch;
        logic [7:0] tcol;
        logic [7:0] trow;
        logic [7:0] attr;
        bit         drain_first;
    } console_cmd_t;

    // one result beat
    typedef struct packed {
        logic [6:0] col;
        logic [4:0] line;
        logic [7:0] ch;
        logic [7:0] attr;
    } console_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [0:0] cfg_index = CFG_COLUMNS;
    logic [7:0] cfg_data = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    func_t      func = FN_WRITE;
    logic [7:0] char_code = 8'd0;
    logic [7:0] target_column = 8'd0;
    logic [7:0] target_row = 8'd0;
    logic [7:0] clear_attr = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [6:0] cursor_col;
    logic [4:0] cursor_line;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;

    text_console_cursor_scroll #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS(MAX_ROWS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .char_code(char_code),
        .target_column(target_column),
        .target_row(target_row),
        .clear_attr(clear_attr),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .cursor_col(cursor_col),
        .cursor_line(cursor_line),
        .cell_char(cell_char),
        .cell_attr(cell_attr)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    console_cmd_t    pending_cmds[$];
    console_result_t expected_results[$];

    // shadow copy of the console
    logic [15:0]  screen_model [0:CELLS-1];
    int unsigned  cur_x = 0;
    int unsigned  cur_y = 0;
    logic [7:0]   attr_now = ATTR_RESET;
    logic [7:0]   cols_reg = COLS_RESET;
    logic [5:0]   rows_reg = ROWS_RESET;

    int unsigned  beats_in = 0;
    int unsigned  beats_out = 0;
    int unsigned  fails = 0;
    int unsigned  n_writes = 0;
    int unsigned  n_moves = 0;
    int unsigned  n_clears = 0;
    int unsigned  n_reads = 0;

    bit           showing = 1'b0;
    bit           calm = 1'b0;

    // stimulus bookkeeping: sizes in use and how much of the grid a clear has covered
    int unsigned  gen_cols = COLS_RESET;
    int unsigned  gen_rows = ROWS_RESET;
    int unsigned  cleared_span = 0;
    int unsigned  queued = 0;
    int unsigned  geometries = 0;

    function automatic int unsigned fit_cols(logic [7:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_COLUMNS)
            return MAX_COLUMNS;
        return v;
    endfunction

    function automatic int unsigned fit_rows(logic [5:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_ROWS)
            return MAX_ROWS;
        return v;
    endfunction

    function automatic int unsigned draw_idle();
        if (calm)
            return 0;
        return $urandom_range(0, 5);
    endfunction

    // cursor to the start of the next line, scrolling the grid up from the last row
    function automatic void start_new_line();
        int unsigned c;
        int unsigned r;
        int unsigned base;
        int unsigned i;
        c = fit_cols(cols_reg);
        r = fit_rows(rows_reg);
        if (cur_y + 1 >= r)
        begin
            base = (r - 1) * c;
            for (i = 0; i < base; i++)
                screen_model[i] = screen_model[i + c];
            // bottom row: blank characters, attributes kept
            for (i = 0; i < c; i++)
                screen_model[base + i][7:0] = CH_SPACE;
            cur_y = r - 1;
        end
        else
        begin
            cur_y++;
        end
        cur_x = 0;
    endfunction

    // apply one command to the shadow console and return its result beat
    function automatic console_result_t console_step(func_t fn, logic [7:0] ch,
                                                     logic [7:0] tcol, logic [7:0] trow,
                                                     logic [7:0] attr);
        int unsigned     c;
        int unsigned     r;
        int unsigned     addr;
        int unsigned     i;
        logic [15:0]     cell_word;
        console_result_t res;
        c = fit_cols(cols_reg);
        r = fit_rows(rows_reg);
        cell_word = 16'h0000;
        case (fn)
            FN_WRITE:
            begin
                n_writes++;
                if (ch == CH_NEWLINE)
                begin
                    start_new_line();
                end
                else if (ch != CH_RETURN)
                begin
                    addr = cur_y * c + cur_x;
                    if (addr < CELLS)
                        screen_model[addr] = {attr_now, ch};
                    cur_x++;
                    if (cur_x >= c)
                        start_new_line();
                end
            end
            FN_MOVE:
            begin
                n_moves++;
                cur_x = tcol % c;
                cur_y = trow % r;
            end
            FN_CLEAR:
            begin
                n_clears++;
                attr_now = attr;
                cur_x = 0;
                cur_y = 0;
                for (i = 0; i < c * r; i++)
                    screen_model[i] = {attr, CH_SPACE};
            end
            default:
            begin
                n_reads++;
                cell_word = screen_model[(trow % r) * c + (tcol % c)];
            end
        endcase
        res.col  = 7'(cur_x);
        res.line = 5'(cur_y);
        res.ch   = cell_word[7:0];
        res.attr = cell_word[15:8];
        return res;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    // rising edge: register writes, accepted commands and accepted results
    always @(posedge clk)
    begin : monitor
        console_result_t want;
        if (rst_n)
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_COLUMNS: cols_reg = cfg_data;
                    CFG_ROWS:    rows_reg = cfg_data[5:0];
                    default:     ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                beats_out++;
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no command outstanding: col %0d line %0d",
                           cursor_col, cursor_line);
                    fails++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("cursor_col", {1'b0, want.col}, {1'b0, cursor_col});
                    check_field("cursor_line", {3'b000, want.line}, {3'b000, cursor_line});
                    check_field("cell_char", want.ch, cell_char);
                    check_field("cell_attr", want.attr, cell_attr);
                end
            end
            if (in_valid && !in_stall)
            begin
                beats_in++;
                expected_results.push_back(console_step(func, char_code, target_column,
                                                        target_row, clear_attr));
            end
        end
    end

    // command sender: a fresh draw of idle cycles before each beat
    always @(negedge clk)
    begin : sender
        console_cmd_t next_cmd;
        int unsigned  beats_shown;
        int unsigned  send_gap;
        if (rst_n)
        begin
            if (showing && beats_in == beats_shown)
                showing = 1'b0;
            if (!showing)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (pending_cmds.size() > 0 &&
                         !(pending_cmds[0].drain_first && expected_results.size() > 0))
                begin
                    next_cmd = pending_cmds.pop_front();
                    func <= next_cmd.fn;
                    char_code <= next_cmd.ch;
                    target_column <= next_cmd.tcol;
                    target_row <= next_cmd.trow;
                    clear_attr <= next_cmd.attr;
                    showing = 1'b1;
                    beats_shown++;
                    send_gap = draw_idle();
                end
            end
            in_valid <= showing;
        end
    end

    // result receiver: stalls each result beat for a random count
    always @(negedge clk)
    begin : receiver
        int unsigned beats_seen;
        int unsigned hold_left;
        if (rst_n)
        begin
            if (beats_out != beats_seen)
            begin
                beats_seen = beats_out;
                hold_left = draw_idle();
            end
            if (out_valid && hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic queue_cmd(func_t fn, logic [7:0] ch, logic [7:0] tcol,
                             logic [7:0] trow, logic [7:0] attr, bit drain_first);
        console_cmd_t cmd;
        // a read is only issued once a clear has covered the whole area in use
        if (fn == FN_READ && gen_cols * gen_rows > cleared_span)
            fn = FN_CLEAR;
        if (fn == FN_CLEAR && gen_cols * gen_rows > cleared_span)
            cleared_span = gen_cols * gen_rows;
        cmd.fn = fn;
        cmd.ch = ch;
        cmd.tcol = tcol;
        cmd.trow = trow;
        cmd.attr = attr;
        cmd.drain_first = drain_first;
        pending_cmds.push_back(cmd);
        queued++;
    endtask

    task automatic queue_random_cmd(bit big);
        int unsigned pick;
        logic [7:0]  ch;
        bit          drain_first;
        pick = $urandom_range(0, 99);
        ch = 8'($urandom_range(0, 255));
        drain_first = ($urandom_range(0, 59) == 0);
        if (pick < 12)
            ch = CH_NEWLINE;
        else if (pick < 16)
            ch = CH_RETURN;
        if (pick < 60)
            queue_cmd(FN_WRITE, ch, 8'($urandom), 8'($urandom), 8'($urandom), drain_first);
        else if (pick < 75)
            queue_cmd(FN_MOVE, ch, 8'($urandom), 8'($urandom), 8'($urandom), drain_first);
        else if (pick < (big ? 99 : 96))
            queue_cmd(FN_READ, ch, 8'($urandom), 8'($urandom), 8'($urandom), drain_first);
        else
            queue_cmd(FN_CLEAR, ch, 8'($urandom), 8'($urandom), 8'($urandom), drain_first);
    endtask

    task automatic wait_quiet();
        while (!(pending_cmds.size() == 0 && !showing && expected_results.size() == 0))
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // reprogram the screen size while the engine is idle
    task automatic set_geometry(logic [7:0] cols_val, logic [7:0] rows_val);
        wait_quiet();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_COLUMNS;
        cfg_data <= cols_val;
        @(negedge clk);
        cfg_index <= CFG_ROWS;
        cfg_data <= rows_val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        gen_cols = fit_cols(cols_val);
        gen_rows = fit_rows(rows_val[5:0]);
        geometries++;
    endtask

    initial
    begin : stimulus
        int unsigned phase_no;
        int unsigned len;
        bit          big;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // full-size grid, registers written above their range
        set_geometry(8'hFF, 8'hFF);
        queue_cmd(FN_CLEAR, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0);
        queue_cmd(FN_READ, 8'h00, 8'hFF, 8'hFF, 8'h00, 1'b0);
        queue_cmd(FN_MOVE, 8'h00, 8'd127, 8'd31, 8'h00, 1'b0);
        queue_cmd(FN_WRITE, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);   // wraps and scrolls
        queue_cmd(FN_READ, 8'h00, 8'd127, 8'd30, 8'h00, 1'b0);
        queue_cmd(FN_WRITE, CH_RETURN, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_cmd(FN_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_cmd(FN_WRITE, CH_NEWLINE, 8'h00, 8'h00, 8'h00, 1'b1);
        queue_cmd(FN_READ, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);

        // zero sizes act as one cell; cursor is left outside the shrunk area
        set_geometry(8'h00, 8'hC0);
        queue_cmd(FN_WRITE, 8'h55, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_cmd(FN_READ, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_cmd(FN_WRITE, CH_NEWLINE, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_cmd(FN_READ, 8'h00, 8'hFF, 8'h80, 8'h00, 1'b0);
        queue_cmd(FN_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_cmd(FN_WRITE, 8'hAA, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_cmd(FN_READ, 8'h00, 8'd200, 8'd3, 8'h00, 1'b0);

        // tiny grid: wrap, scroll and modulo targets
        set_geometry(8'd3, 8'd2);
        queue_cmd(FN_MOVE, 8'h00, 8'd5, 8'd3, 8'h00, 1'b0);
        queue_cmd(FN_WRITE, 8'h71, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_cmd(FN_WRITE, CH_NEWLINE, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_cmd(FN_READ, 8'h00, 8'd2, 8'd0, 8'h00, 1'b0);
        queue_cmd(FN_READ, 8'h00, 8'd0, 8'd1, 8'h00, 1'b0);
        queue_cmd(FN_MOVE, 8'h00, 8'hFF, 8'hFF, 8'h00, 1'b0);

        // random phases, mostly small grids, one at full size
        queued = 0;
        phase_no = 0;
        while (queued < RANDOM_CMDS)
        begin
            big = (phase_no == 3);
            if (big)
            begin
                set_geometry(8'($urandom_range(128, 255)),
                             {2'($urandom), 6'($urandom_range(32, 63))});
                len = 30;
            end
            else
            begin
                set_geometry(8'($urandom_range(0, 20)),
                             {2'($urandom), 6'($urandom_range(0, 10))});
                len = $urandom_range(40, 120);
            end
            calm = ($urandom_range(0, 3) == 0);
            if (gen_cols * gen_rows > cleared_span || $urandom_range(0, 3) == 0)
                queue_cmd(FN_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 1'b0);
            repeat (len)
                queue_random_cmd(big);
            phase_no++;
        end

        wait_quiet();
        repeat (32) @(negedge clk);
        $display("%0d commands checked: %0d writes, %0d moves, %0d clears, %0d reads",
                 beats_out, n_writes, n_moves, n_clears, n_reads);
        $display("over %0d screen geometries, %0d failures", geometries, fails);
        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_CYCLES * 4);
        $display("simulation failed");
        $finish;
    end

endmodule
